// ===== hdl/avc_sps_pkg.sv =====
// ----------------------------------------------------------------------------
// avc_sps_pkg
// Shared types and constants of the SPS resolution parser.
// ----------------------------------------------------------------------------
package avc_sps_pkg;

  localparam int DEF_MAX_DIM_CODE_BITS = 16;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;

  typedef struct packed {
    logic [7:0] sps_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [20:0] pic_width;
    logic [21:0] pic_height;
    logic [1:0]  parse_status;
  } out_word_t;

  // status of one parse, handed from the bit walker to the byte sequencer
  typedef struct packed {
    logic        done;
    logic [1:0]  err;
    logic [20:0] width;
    logic [16:0] hunits;
    logic        field;
  } parse_stat_t;

endpackage

// ===== hdl/avc_sps_if.sv =====
// ----------------------------------------------------------------------------
// avc_sps_in_if / avc_sps_out_if
// Valid/ready channels for SPS bytes and parse results.
// ----------------------------------------------------------------------------
interface avc_sps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sps_byte;
  logic       last_byte;
  modport source (output valid, sps_byte, last_byte, input ready);
  modport sink (input valid, sps_byte, last_byte, output ready);
endinterface

interface avc_sps_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] pic_width;
  logic [21:0] pic_height;
  logic [1:0]  parse_status;
  modport source (output valid, pic_width, pic_height, parse_status, input ready);
  modport sink (input valid, pic_width, pic_height, parse_status, output ready);
endinterface

// ===== hdl/avc_sps_walker.sv =====
// ----------------------------------------------------------------------------
// avc_sps_walker
// Bit-serial SPS syntax walker with one shared exp-Golomb decoder.
// ----------------------------------------------------------------------------
module avc_sps_walker #(
  parameter int MAX_DIM_CODE_BITS = avc_sps_pkg::DEF_MAX_DIM_CODE_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic                     bit_en,
  input  logic                     bit_in,
  output avc_sps_pkg::parse_stat_t stat
);
  import avc_sps_pkg::*;

  localparam logic [4:0] S_HDR = 5'd0, S_PROFILE = 5'd1, S_SKIP16 = 5'd2,
    S_SPS_ID = 5'd3, S_CHROMA = 5'd4, S_SEP_PLANE = 5'd5, S_DEPTH_L = 5'd6,
    S_DEPTH_C = 5'd7, S_BYPASS = 5'd8, S_MATRIX = 5'd9, S_LIST_FLAG = 5'd10,
    S_LIST_DELTA = 5'd11, S_LOG2FN = 5'd12, S_POC_TYPE = 5'd13,
    S_POC_LSB = 5'd14, S_ALWAYS_ZERO = 5'd15, S_OFF_NONREF = 5'd16,
    S_OFF_TB = 5'd17, S_NUM_CYCLE = 5'd18, S_REF_OFF = 5'd19,
    S_NUM_REF = 5'd20, S_GAPS = 5'd21, S_WIDTH = 5'd22, S_HEIGHT = 5'd23,
    S_FRAME_MBS = 5'd24, S_DONE = 5'd25;
  localparam logic [4:0] DIM_LIMIT = 5'(MAX_DIM_CODE_BITS);

  logic [4:0]  syntax_step, syntax_step_next;
  logic [4:0]  bit_counter, bit_counter_next;
  logic [4:0]  golomb_zero_count, golomb_zero_count_next;
  logic [31:0] golomb_value, golomb_value_next;
  logic [7:0]  profile_code, profile_code_next;
  logic [2:0]  list_index, list_index_next;
  logic [6:0]  list_entry_count, list_entry_count_next;
  logic [7:0]  last_scale_value, last_scale_value_next;
  logic [31:0] ref_offset_remaining, ref_offset_remaining_next;
  logic [20:0] width_result, width_result_next;
  logic [16:0] height_units, height_units_next;
  logic        field_coded, field_coded_next;
  logic        finished_flag, finished_flag_next;
  logic [1:0]  error_code, error_code_next;

  // shared decoder outputs
  logic        g_done;
  logic [31:0] g_val;
  logic        g_fail;
  logic [4:0]  g_limit;
  logic        is_golomb;

  always_comb begin
    g_done = 1'b0;
    g_val = '0;
    g_fail = 1'b0;
    golomb_value_next = golomb_value;
    golomb_zero_count_next = golomb_zero_count;
    g_limit = (syntax_step == S_WIDTH || syntax_step == S_HEIGHT) ? DIM_LIMIT : 5'd31;
    if (golomb_value == '0) begin
      if (!bit_in) begin
        if (golomb_zero_count >= g_limit) g_fail = 1'b1;
        else golomb_zero_count_next = golomb_zero_count + 5'd1;
      end else if (golomb_zero_count == '0) begin
        g_done = 1'b1;
      end else begin
        golomb_value_next = 32'd1;
      end
    end else begin
      golomb_value_next = {golomb_value[30:0], bit_in};
      if (bit_counter == 5'd1) begin
        g_done = 1'b1;
        g_val = {golomb_value[30:0], bit_in} - 32'd1;
        golomb_value_next = '0;
        golomb_zero_count_next = '0;
      end
    end
  end

  logic [7:0] delta8, scale_sum;
  logic       list_end;
  logic [6:0] list_len;

  always_comb begin
    delta8 = g_val[0] ? 8'(g_val[8:1] + 8'd1) : 8'(8'd0 - g_val[8:1]);
    scale_sum = last_scale_value + delta8;
    list_len = (list_index < 3'd6) ? 7'd16 : 7'd64;
  end

  always_comb begin
    syntax_step_next = syntax_step;
    bit_counter_next = bit_counter;
    profile_code_next = profile_code;
    list_index_next = list_index;
    list_entry_count_next = list_entry_count;
    last_scale_value_next = last_scale_value;
    ref_offset_remaining_next = ref_offset_remaining;
    width_result_next = width_result;
    height_units_next = height_units;
    field_coded_next = field_coded;
    finished_flag_next = finished_flag;
    error_code_next = error_code;
    is_golomb = 1'b0;
    list_end = 1'b0;
    unique case (syntax_step)
      S_HDR, S_PROFILE, S_SKIP16: begin
        if (syntax_step == S_PROFILE) profile_code_next = {profile_code[6:0], bit_in};
        bit_counter_next = bit_counter + 5'd1;
        if (bit_counter_next >= ((syntax_step == S_SKIP16) ? 5'd16 : 5'd8)) begin
          bit_counter_next = '0;
          syntax_step_next = syntax_step + 5'd1;
        end
      end
      S_SPS_ID: begin
        is_golomb = 1'b1;
        if (g_done)
          syntax_step_next = (profile_code == 8'd100 || profile_code == 8'd110 ||
                              profile_code == 8'd122 || profile_code == 8'd144)
                             ? S_CHROMA : S_LOG2FN;
      end
      S_CHROMA: begin
        is_golomb = 1'b1;
        if (g_done) syntax_step_next = (g_val == 32'd3) ? S_SEP_PLANE : S_DEPTH_L;
      end
      S_SEP_PLANE: syntax_step_next = S_DEPTH_L;
      S_DEPTH_L, S_DEPTH_C, S_OFF_NONREF, S_OFF_TB: begin
        is_golomb = 1'b1;
        if (g_done) syntax_step_next = syntax_step + 5'd1;
      end
      S_BYPASS: syntax_step_next = S_MATRIX;
      S_MATRIX: begin
        list_index_next = '0;
        syntax_step_next = bit_in ? S_LIST_FLAG : S_LOG2FN;
      end
      S_LIST_FLAG: begin
        if (bit_in) begin
          last_scale_value_next = 8'd8;
          list_entry_count_next = '0;
          syntax_step_next = S_LIST_DELTA;
        end else list_end = 1'b1;
      end
      S_LIST_DELTA: begin
        is_golomb = 1'b1;
        if (g_done) begin
          if (scale_sum != '0) last_scale_value_next = scale_sum;
          list_entry_count_next = list_entry_count + 7'd1;
          if (scale_sum == '0 || list_entry_count_next >= list_len) list_end = 1'b1;
        end
      end
      S_LOG2FN: begin
        is_golomb = 1'b1;
        if (g_done) syntax_step_next = S_POC_TYPE;
      end
      S_POC_TYPE: begin
        is_golomb = 1'b1;
        if (g_done)
          syntax_step_next = (g_val == 32'd0) ? S_POC_LSB :
                             (g_val == 32'd1) ? S_ALWAYS_ZERO : S_NUM_REF;
      end
      S_POC_LSB: begin
        is_golomb = 1'b1;
        if (g_done) syntax_step_next = S_NUM_REF;
      end
      S_ALWAYS_ZERO: syntax_step_next = S_OFF_NONREF;
      S_NUM_CYCLE: begin
        is_golomb = 1'b1;
        if (g_done) begin
          ref_offset_remaining_next = g_val;
          syntax_step_next = (g_val == '0) ? S_NUM_REF : S_REF_OFF;
        end
      end
      S_REF_OFF: begin
        is_golomb = 1'b1;
        if (g_done) begin
          ref_offset_remaining_next = ref_offset_remaining - 32'd1;
          if (ref_offset_remaining == 32'd1) syntax_step_next = S_NUM_REF;
        end
      end
      S_NUM_REF: begin
        is_golomb = 1'b1;
        if (g_done) syntax_step_next = S_GAPS;
      end
      S_GAPS: syntax_step_next = S_WIDTH;
      S_WIDTH, S_HEIGHT: begin
        is_golomb = 1'b1;
        if (g_done) begin
          if (g_val > 32'd65535) begin
            error_code_next = ST_LONG;
            finished_flag_next = 1'b1;
          end else if (syntax_step == S_WIDTH) begin
            width_result_next = {g_val[16:0] + 17'd1, 4'd0};
            syntax_step_next = S_HEIGHT;
          end else begin
            height_units_next = g_val[16:0] + 17'd1;
            syntax_step_next = S_FRAME_MBS;
          end
        end
      end
      S_FRAME_MBS: begin
        field_coded_next = !bit_in;
        finished_flag_next = 1'b1;
        syntax_step_next = S_DONE;
      end
      default: finished_flag_next = 1'b1;
    endcase
    if (list_end) begin
      if (list_index == 3'd7) begin
        list_index_next = '0;
        syntax_step_next = S_LOG2FN;
      end else begin
        list_index_next = list_index + 3'd1;
        syntax_step_next = S_LIST_FLAG;
      end
    end
    if (is_golomb) begin
      if (g_fail) begin
        error_code_next = ST_LONG;
        finished_flag_next = 1'b1;
      end else if (golomb_value == '0 && bit_in && golomb_zero_count != '0)
        bit_counter_next = golomb_zero_count;
      else if (golomb_value != '0)
        bit_counter_next = bit_counter - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      syntax_step <= S_HDR;
      bit_counter <= '0;
      golomb_zero_count <= '0;
      golomb_value <= '0;
      profile_code <= '0;
      list_index <= '0;
      list_entry_count <= '0;
      last_scale_value <= 8'd8;
      ref_offset_remaining <= '0;
      width_result <= '0;
      height_units <= '0;
      field_coded <= 1'b0;
      finished_flag <= 1'b0;
      error_code <= '0;
    end else if (bit_en && !finished_flag) begin
      syntax_step <= syntax_step_next;
      bit_counter <= bit_counter_next;
      if (is_golomb) begin
        golomb_zero_count <= golomb_zero_count_next;
        golomb_value <= golomb_value_next;
      end
      profile_code <= profile_code_next;
      list_index <= list_index_next;
      list_entry_count <= list_entry_count_next;
      last_scale_value <= last_scale_value_next;
      ref_offset_remaining <= ref_offset_remaining_next;
      width_result <= width_result_next;
      height_units <= height_units_next;
      field_coded <= field_coded_next;
      finished_flag <= finished_flag_next;
      error_code <= error_code_next;
    end
  end

  assign stat.done = finished_flag && syntax_step == S_DONE;
  assign stat.err = error_code;
  assign stat.width = width_result;
  assign stat.hunits = height_units;
  assign stat.field = field_coded;

  a_err_finish: assert property (@(posedge clk) disable iff (rst)
    error_code != '0 |-> finished_flag) else $error("error without finish");
  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    syntax_step == S_DONE |-> finished_flag) else $error("done without finish");
  a_frozen: assert property (@(posedge clk) disable iff (rst)
    finished_flag && !clear && !$past(rst) |=> $stable(syntax_step))
    else $error("walker advanced after finish");
endmodule

// ===== hdl/avc_sps_resolution_parser_core.sv =====
// ----------------------------------------------------------------------------
// avc_sps_resolution_parser_core
// Byte-in, result-out shell around the bit-serial SPS walker.
// ----------------------------------------------------------------------------
// Usage: feed the bytes of one SPS NAL unit on in_ch, header byte first, and
// mark the final byte with last_byte. Each byte is shifted into the walker one
// bit per cycle, and ready is low while a byte is being shifted; the
// shift register of this shell sets this rate. After a byte with
// last_byte set, one word comes out on out_ch: width, height and status
// (0 ok, 1 truncated, 2 code too long), the sizes zero unless ok. The result
// passes through the emit flag into an output register and waits there; the
// next unit's bytes are taken while it waits, but a further result cannot be
// formed until that word leaves, so a stalled receiver stalls the input at
// the next last byte. Reset empties the output and returns the walker to the
// start of a NAL unit.
// ----------------------------------------------------------------------------
module avc_sps_resolution_parser_core #(
  parameter int MAX_DIM_CODE_BITS = avc_sps_pkg::DEF_MAX_DIM_CODE_BITS
) (
  input  logic          clk,
  input  logic          rst,
  avc_sps_in_if.sink    in_ch,
  avc_sps_out_if.source out_ch
);
  import avc_sps_pkg::*;

  logic       busy;
  logic [2:0] bit_idx;
  logic [7:0] shreg;
  logic       is_last;
  logic       emit;
  logic       clear;
  parse_stat_t stat;
  out_word_t  res;

  assign in_ch.ready = !busy && !emit;
  assign clear = emit && !(out_ch.valid && !out_ch.ready);

  avc_sps_walker #(.MAX_DIM_CODE_BITS(MAX_DIM_CODE_BITS)) u_walker (
    .clk(clk), .rst(rst), .clear(clear), .bit_en(busy),
    .bit_in(shreg[7]), .stat(stat)
  );

  always_comb begin
    res = '0;
    if (stat.err != '0) res.parse_status = stat.err;
    else if (stat.done) begin
      res.pic_width = stat.width;
      res.pic_height = stat.field ? {stat.hunits, 5'd0} : {1'b0, stat.hunits, 4'd0};
    end else res.parse_status = ST_TRUNC;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      bit_idx <= '0;
      emit <= 1'b0;
      is_last <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (clear) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        busy <= 1'b1;
        bit_idx <= '0;
        shreg <= in_ch.sps_byte;
        is_last <= in_ch.last_byte;
      end else if (busy) begin
        shreg <= {shreg[6:0], 1'b0};
        bit_idx <= bit_idx + 3'd1;
        if (bit_idx == 3'd7) begin
          busy <= 1'b0;
          emit <= is_last;
        end
      end
      if (clear) begin
        emit <= 1'b0;
        out_ch.pic_width <= res.pic_width;
        out_ch.pic_height <= res.pic_height;
        out_ch.parse_status <= res.parse_status;
      end
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ch.ready) else $error("accepted during byte");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.parse_status != 2'd3) else $error("bad status");
  a_zero_on_err: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.parse_status != ST_OK |-> out_ch.pic_width == '0)
    else $error("size on error");
endmodule

// ===== test/avc_sps_resolution_parser_core_test.sv =====
// ----------------------------------------------------------------------------
// avc_sps_resolution_parser_core_test
// Feeds whole SPS NAL units (well-formed, with random syntax content, plus
// truncated, overlong and noise units) byte by byte and checks every result
// word against a bit-serial predictor of the parser kept in this bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module avc_sps_resolution_parser_core_test;
  import avc_sps_pkg::*;

  typedef enum int {
    P_HDR, P_PROFILE, P_SKIP16, P_SPS_ID, P_CHROMA, P_SEP_PLANE, P_DEPTH_L,
    P_DEPTH_C, P_BYPASS, P_MATRIX, P_LIST_FLAG, P_LIST_DELTA, P_LOG2FN,
    P_POC_TYPE, P_POC_LSB, P_ALWAYS_ZERO, P_OFF_NONREF, P_OFF_TB,
    P_NUM_CYCLE, P_REF_OFF, P_NUM_REF, P_GAPS, P_WIDTH, P_HEIGHT,
    P_FRAME_MBS, P_DONE
  } sps_step_e;

  localparam int DIM_BITS = DEF_MAX_DIM_CODE_BITS;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  avc_sps_in_if  in_ch ();
  avc_sps_out_if out_ch ();

  avc_sps_resolution_parser_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #6 clk = ~clk;

  // parser state mirrored by the predictor
  sps_step_e   step;
  int unsigned bitcnt, zcnt, gval, profile, lidx, lcnt, last_sc, next_sc;
  int unsigned ref_left, wres, hunits;
  bit          field_mb, finished;
  logic [1:0]  err;

  in_word_t    pending_words[$];
  out_word_t   expected_words[$];
  int          errors = 0;
  int          waiting_units = 0;
  bit          drained_pause = 0;
  bit          sender_calm, receiver_calm;

  // bit string builder for well-formed units
  bit          bits[$];

  task automatic parser_clear();
    step = P_HDR; bitcnt = 0; zcnt = 0; gval = 0; profile = 0; lidx = 0;
    lcnt = 0; last_sc = 8; next_sc = 8; ref_left = 0; wres = 0; hunits = 0;
    field_mb = 0; finished = 0; err = ST_OK;
  endtask

  function automatic bit golomb_take(bit b, int unsigned lim,
                                     output int unsigned val);
    val = 0;
    if (gval == 0) begin
      if (!b) begin
        if (zcnt >= lim) begin
          err = ST_LONG; finished = 1;
        end else begin
          zcnt++;
        end
        return 0;
      end
      if (zcnt == 0) return 1;
      gval = 1; bitcnt = zcnt;
      return 0;
    end
    gval = (gval << 1) | b;
    bitcnt--;
    if (bitcnt == 0) begin
      val = gval - 1; gval = 0; zcnt = 0;
      return 1;
    end
    return 0;
  endfunction

  task automatic advance_list();
    if (lidx >= 7) begin
      lidx = 0; step = P_LOG2FN;
    end else begin
      lidx++; step = P_LIST_FLAG;
    end
  endtask

  task automatic parser_bit(bit b);
    int unsigned v, d;
    case (step)
      P_HDR, P_PROFILE, P_SKIP16: begin
        if (step == P_PROFILE) profile = ((profile << 1) | b) & 8'hFF;
        bitcnt++;
        if (bitcnt >= ((step == P_SKIP16) ? 16 : 8)) begin
          bitcnt = 0; step = sps_step_e'(step + 1);
        end
      end
      P_SPS_ID: if (golomb_take(b, 31, v))
        step = (profile inside {100, 110, 122, 144}) ? P_CHROMA : P_LOG2FN;
      P_CHROMA: if (golomb_take(b, 31, v))
        step = (v == 3) ? P_SEP_PLANE : P_DEPTH_L;
      P_SEP_PLANE: step = P_DEPTH_L;
      P_DEPTH_L, P_DEPTH_C, P_OFF_NONREF, P_OFF_TB:
        if (golomb_take(b, 31, v)) step = sps_step_e'(step + 1);
      P_BYPASS: step = P_MATRIX;
      P_MATRIX: begin
        lidx = 0; step = b ? P_LIST_FLAG : P_LOG2FN;
      end
      P_LIST_FLAG: begin
        if (b) begin
          last_sc = 8; next_sc = 8; lcnt = 0; step = P_LIST_DELTA;
        end else begin
          advance_list();
        end
      end
      P_LIST_DELTA: if (golomb_take(b, 31, v)) begin
        d = v[0] ? (v >> 1) + 1 : 0 - (v >> 1);
        next_sc = (last_sc + d) & 8'hFF;
        if (next_sc != 0) last_sc = next_sc;
        lcnt++;
        if (next_sc == 0 || lcnt >= ((lidx < 6) ? 16 : 64)) advance_list();
      end
      P_LOG2FN: if (golomb_take(b, 31, v)) step = P_POC_TYPE;
      P_POC_TYPE: if (golomb_take(b, 31, v))
        step = (v == 0) ? P_POC_LSB : (v == 1) ? P_ALWAYS_ZERO : P_NUM_REF;
      P_POC_LSB: if (golomb_take(b, 31, v)) step = P_NUM_REF;
      P_ALWAYS_ZERO: step = P_OFF_NONREF;
      P_NUM_CYCLE: if (golomb_take(b, 31, v)) begin
        ref_left = v; step = (v == 0) ? P_NUM_REF : P_REF_OFF;
      end
      P_REF_OFF: if (golomb_take(b, 31, v)) begin
        ref_left--;
        if (ref_left == 0) step = P_NUM_REF;
      end
      P_NUM_REF: if (golomb_take(b, 31, v)) step = P_GAPS;
      P_GAPS: step = P_WIDTH;
      P_WIDTH, P_HEIGHT: if (golomb_take(b, DIM_BITS, v)) begin
        if (v > 65535) begin
          err = ST_LONG; finished = 1;
        end else if (step == P_WIDTH) begin
          wres = (v + 1) * 16; step = P_HEIGHT;
        end else begin
          hunits = v + 1; step = P_FRAME_MBS;
        end
      end
      P_FRAME_MBS: begin
        field_mb = !b; finished = 1; step = P_DONE;
      end
      default: finished = 1;
    endcase
  endtask

  // predict on each accepted byte
  task automatic parse_byte(in_word_t w);
    out_word_t r;
    for (int i = 7; i >= 0; i--) begin
      if (finished) break;
      parser_bit(w.sps_byte[i]);
    end
    if (w.last_byte) begin
      r = '0;
      if (err != ST_OK) begin
        r.parse_status = err;
      end else if (finished && step == P_DONE) begin
        r.pic_width = wres[20:0];
        r.pic_height = 22'(hunits * 16 * (field_mb ? 2 : 1));
        r.parse_status = ST_OK;
      end else begin
        r.parse_status = ST_TRUNC;
      end
      expected_words.push_back(r);
      parser_clear();
    end
  endtask

  task automatic put_bits(longint unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) bits.push_back(v[i]);
  endtask

  task automatic put_ue(longint unsigned v);
    longint unsigned c = v + 1;
    int n = 0;
    while ((c >> n) > 1) n++;
    put_bits(0, n);
    put_bits(c, n + 1);
  endtask

  task automatic put_se(int v);
    put_ue(v > 0 ? 2 * v - 1 : -2 * v);
  endtask

  function automatic int unsigned small_ue();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(1, 6);
      2: return $urandom_range(7, 300);
      default: return $urandom_range(0, 40000);
    endcase
  endfunction

  // pack the bit string into bytes; cut shortens the unit
  task automatic flush_unit(int cut);
    in_word_t w;
    int nbytes;
    while (bits.size() % 8 != 0) bits.push_back($urandom_range(0, 1));
    nbytes = bits.size() / 8 - cut;
    if (nbytes < 1) nbytes = 1;
    for (int k = 0; k < nbytes; k++) begin
      for (int i = 0; i < 8; i++) w.sps_byte[7 - i] = bits[k * 8 + i];
      w.last_byte = (k == nbytes - 1);
      pending_words.push_back(w);
    end
    bits.delete();
  endtask

  // one SPS built from the given fields plus random content
  task automatic build_sps(int prof, int poc, longint unsigned wcode,
                           longint unsigned hcode, bit lists, int cut);
    int unsigned pick[4] = '{100, 110, 122, 144};
    put_bits($urandom_range(0, 255), 8);
    put_bits(prof, 8);
    put_bits($urandom_range(0, 65535), 16);
    put_ue(small_ue());
    if (prof inside {100, 110, 122, 144}) begin
      int unsigned chroma = $urandom_range(0, 3);
      put_ue(chroma);
      if (chroma == 3) put_bits($urandom_range(0, 1), 1);
      put_ue($urandom_range(0, 6));
      put_ue($urandom_range(0, 6));
      put_bits($urandom_range(0, 1), 1);
      put_bits(lists, 1);
      if (lists) begin
        for (int l = 0; l < 8; l++) begin
          bit on = $urandom_range(0, 2) == 0;
          put_bits(on, 1);
          if (on) begin
            int n = (l < 6) ? 16 : 64;
            int sc = 8;
            for (int e = 0; e < n; e++) begin
              int d;
              if ($urandom_range(0, 20) == 0) d = -sc;
              else if ($urandom_range(0, 10) == 0) d = $urandom_range(0, 255) - 128;
              else d = $urandom_range(0, 6) - 3;
              put_se(d);
              sc = (sc + d) & 255;
              if (sc == 0) break;
            end
          end
        end
      end
    end
    put_ue($urandom_range(0, 12));
    put_ue(poc);
    if (poc == 0) put_ue($urandom_range(0, 12));
    else if (poc == 1) begin
      int unsigned ncyc = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                               : $urandom_range(0, 40);
      put_bits($urandom_range(0, 1), 1);
      put_ue(small_ue()); put_ue(small_ue());
      put_ue(ncyc);
      for (int i = 0; i < ncyc; i++) put_ue(small_ue());
    end
    put_ue($urandom_range(0, 16));
    put_bits($urandom_range(0, 1), 1);
    put_ue(wcode);
    put_ue(hcode);
    put_bits($urandom_range(0, 1), 1);
    put_bits($urandom, $urandom_range(0, 40));
    flush_unit(cut);
    waiting_units++;
    if (pick[0] == 0) waiting_units--;
  endtask

  function automatic int rand_profile();
    int unsigned hp[4] = '{100, 110, 122, 144};
    return $urandom_range(0, 1) ? hp[$urandom_range(0, 3)] : $urandom_range(0, 255);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // stimulus
  initial begin
    in_word_t w;
    parser_clear();
    // directed: profile branches, POC types 0, 1 and 2, extremes of size
    build_sps(66, 0, 0, 0, 0, 0);
    build_sps(100, 1, 65535, 65535, 1, 0);
    build_sps(144, 2, 119, 67, 1, 0);
    build_sps(77, 1, 65536, 5, 0, 0);          // oversized width
    build_sps(77, 2, 10, 65536, 0, 0);         // oversized height
    build_sps(110, 0, 21'h1FFFF, 3, 0, 0);     // width code over the length cap
    build_sps(122, 0, 44, 35, 1, 3);           // last three bytes cut off
    // header-only units, all ones, all zeros
    w.sps_byte = 8'hFF; w.last_byte = 1; pending_words.push_back(w);
    for (int i = 0; i < 9; i++) begin
      w.sps_byte = 8'h00; w.last_byte = (i == 8); pending_words.push_back(w);
    end
    for (int i = 0; i < 6; i++) begin
      w.sps_byte = 8'hFF; w.last_byte = (i == 5); pending_words.push_back(w);
    end
    while (pending_words.size() < 750) begin
      case ($urandom_range(0, 9))
        0: begin
          int n;
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) begin
            w.sps_byte = $urandom_range(0, 255);
            w.last_byte = (i == n - 1);
            pending_words.push_back(w);
          end
        end
        1: build_sps(rand_profile(), $urandom_range(0, 3), small_ue(), small_ue(),
                     $urandom_range(0, 1), $urandom_range(1, 6));
        2: build_sps(rand_profile(), $urandom_range(0, 2),
                     $urandom_range(0, 1) ? $urandom_range(65530, 140000) : small_ue(),
                     $urandom_range(0, 1) ? $urandom_range(65530, 140000) : small_ue(),
                     $urandom_range(0, 1), 0);
        default: build_sps(rand_profile(), $urandom_range(0, 3), small_ue(), small_ue(),
                           $urandom_range(0, 1), 0);
      endcase
    end
  end

  // sender
  int sent = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.sps_byte <= '0;
      in_ch.last_byte <= 1'b0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      sender_calm = (sent > 200 && sent < 350);
      if (!drained_pause && sent == 400 && expected_words.size() != 0) begin
        in_ch.valid <= 1'b0;   // hold until every result is back
      end else if (pending_words.size() != 0 &&
                   (sender_calm || $urandom_range(0, 99) >= 11)) begin
        if (sent == 400) drained_pause = 1;
        in_ch.valid <= 1'b1;
        in_ch.sps_byte <= pending_words[0].sps_byte;
        in_ch.last_byte <= pending_words[0].last_byte;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver ready
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      receiver_calm = (sent > 500 && sent < 650);
      out_ch.ready <= receiver_calm || $urandom_range(0, 99) >= 11;
    end
  end

  // monitor and checker
  int idle_cycles = 0;
  always @(posedge clk) begin
    out_word_t e;
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_ch.valid && in_ch.ready) begin
        parse_byte(pending_words.pop_front());
        sent <= sent + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected result words", 1, 0);
        end else begin
          e = expected_words.pop_front();
          if (out_ch.parse_status !== e.parse_status)
            report_mismatch("parse_status", out_ch.parse_status, e.parse_status);
          if (out_ch.pic_width !== e.pic_width)
            report_mismatch("pic_width", out_ch.pic_width, e.pic_width);
          if (out_ch.pic_height !== e.pic_height)
            report_mismatch("pic_height", out_ch.pic_height, e.pic_height);
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("avc_sps_resolution_parser_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (sent > 0 && pending_words.size() == 0 && !in_ch.valid);
    wait (expected_words.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("avc_sps_resolution_parser_core regression: pass");
    end else begin
      $display("avc_sps_resolution_parser_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== avc_sps_resolution_parser_core.f =====
hdl/avc_sps_pkg.sv
hdl/avc_sps_if.sv
hdl/avc_sps_walker.sv
hdl/avc_sps_resolution_parser_core.sv
test/avc_sps_resolution_parser_core_test.sv
